// ===== hdl/ldm_pkg.sv =====
// Shared types and constants for the landmark dedup map.
package ldm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int COORD_W     = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int DIST_W      = 2 * DIFF_W;
  localparam int CFG_W       = 40;
  localparam int NEAR_D_W    = 49;
  localparam int COUNT_OUT_W = 9;

  localparam int DIST_LAT    = 3;
  localparam int DRAIN_W     = $clog2(DIST_LAT);

  localparam logic OP_OFFER   = 1'b0;
  localparam logic OP_QUERY   = 1'b1;
  localparam logic TBL_CONE   = 1'b0;
  localparam logic TBL_BARREL = 1'b1;

  typedef enum logic [1:0] {
    CFG_DEDUP_RADIUS = 2'd0,
    CFG_RANGE_LIMIT  = 2'd1,
    CFG_UTURN_RADIUS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   is_range;
    entry_t pos;
  } dist_tag_t;

  typedef struct packed {
    logic                      op;
    logic                      table_select;
    logic signed [COORD_W-1:0] land_x;
    logic signed [COORD_W-1:0] land_y;
    logic signed [COORD_W-1:0] ego_x;
    logic signed [COORD_W-1:0] ego_y;
  } in_t;

  typedef struct packed {
    logic                      accepted;
    logic                      table_full;
    logic                      found;
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic [NEAR_D_W-1:0]       near_dist_sq;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      uturn;
  } out_t;

endpackage

// ===== hdl/ldm_cell.sv =====
// One table entry cell: rotates to its neighbor or loads a new entry.
module ldm_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic            load_i,
  input  ldm_pkg::entry_t next_i,
  input  ldm_pkg::entry_t wdata_i,
  output ldm_pkg::entry_t q_o
);

  ldm_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= next_i;
    end else if (load_i) begin
      entry_q <= wdata_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ===== hdl/ldm_chain.sv =====
// Rotating ring of entry cells holding one landmark table.
module ldm_chain (
  input  logic                      clk_i,
  input  logic                      rot_i,
  input  logic                      wr_i,
  input  logic [ldm_pkg::IDX_W-1:0] widx_i,
  input  ldm_pkg::entry_t           wdata_i,
  output ldm_pkg::entry_t           head_o
);

  ldm_pkg::entry_t cell_q [ldm_pkg::TABLE_DEPTH];

  for (genvar i = 0; i < ldm_pkg::TABLE_DEPTH; i++) begin : g_cell
    ldm_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (rot_i),
      .load_i  (wr_i && (widx_i == ldm_pkg::IDX_W'(i))),
      .next_i  (cell_q[(i + 1) % ldm_pkg::TABLE_DEPTH]),
      .wdata_i (wdata_i),
      .q_o     (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

// ===== hdl/ldm_dist.sv =====
// Pipelined squared Euclidean distance unit with a tag carried alongside.
module ldm_dist (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ldm_pkg::entry_t                  a_i,
  input  ldm_pkg::entry_t                  b_i,
  input  ldm_pkg::dist_tag_t               tag_i,
  output logic [ldm_pkg::DIST_W-1:0]       dist_o,
  output ldm_pkg::dist_tag_t               tag_o
);

  logic signed [ldm_pkg::DIFF_W-1:0] diff_x, diff_y;
  logic [ldm_pkg::DIFF_W-1:0]        dx_d, dy_d, dx_q, dy_q;
  logic [ldm_pkg::DIST_W-1:0]        sqx_q, sqy_q, sum_q;
  ldm_pkg::dist_tag_t                tag1_q, tag2_q, tag3_q;

  always_comb begin
    diff_x = {a_i.x[ldm_pkg::COORD_W-1], a_i.x} - {b_i.x[ldm_pkg::COORD_W-1], b_i.x};
    diff_y = {a_i.y[ldm_pkg::COORD_W-1], a_i.y} - {b_i.y[ldm_pkg::COORD_W-1], b_i.y};
    dx_d   = diff_x[ldm_pkg::DIFF_W-1] ? ldm_pkg::DIFF_W'(-diff_x) : ldm_pkg::DIFF_W'(diff_x);
    dy_d   = diff_y[ldm_pkg::DIFF_W-1] ? ldm_pkg::DIFF_W'(-diff_y) : ldm_pkg::DIFF_W'(diff_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sqx_q <= ldm_pkg::DIST_W'(dx_q) * ldm_pkg::DIST_W'(dx_q);
    sqy_q <= ldm_pkg::DIST_W'(dy_q) * ldm_pkg::DIST_W'(dy_q);
    sum_q <= sqx_q + sqy_q;
  end

  assign dist_o = sum_q;
  assign tag_o  = tag3_q;

endmodule

// ===== hdl/landmark_dedup_map_top.sv =====
// Landmark dedup map: range check, dedup scan and nearest-entry query.
// done_o pulses once start is taken and ST_RANGE, ST_SCAN, ST_DRAIN and ST_FINISH have run in turn.
// One transaction at a time: start is taken only while busy is low; the cell ring makes one
// full rotation through the shared distance pipeline per transaction.
// Reset: tables hold unknown data, counts, u-turn latch and config return to defaults.
// The receiver cannot stall: done_o pulses for one cycle per result; result_o holds it until the next.
module landmark_dedup_map_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ldm_pkg::in_t               item_i,
  output logic                       done_o,
  output ldm_pkg::out_t              result_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ldm_pkg::CFG_W-1:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e                             state_q;
  ldm_pkg::in_t                       item_q;
  logic [ldm_pkg::IDX_W-1:0]          k_q;
  logic [ldm_pkg::DRAIN_W-1:0]        drain_q;
  logic [ldm_pkg::CNT_W-1:0]          cone_cnt_q, barrel_cnt_q;
  logic                               uturn_q;
  logic                               in_range_q, dup_q, found_q;
  logic [ldm_pkg::DIST_W-1:0]         best_q;
  ldm_pkg::entry_t                    best_pos_q;
  logic                               done_q;
  ldm_pkg::out_t                      result_q;
  logic [ldm_pkg::CFG_W-1:0]          dedup_q, range_q, uturn_rad_q;

  ldm_pkg::entry_t                    cone_head, barrel_head, head, land, ego;
  ldm_pkg::entry_t                    feed_a, feed_b;
  ldm_pkg::dist_tag_t                 feed_tag, dist_tag;
  logic [ldm_pkg::DIST_W-1:0]         dist_val;
  logic [ldm_pkg::CNT_W-1:0]          sel_cnt, cnt_after;
  logic                               is_barrel, is_query;
  logic                               new_entry, room, do_write, uturn_set;
  logic                               cone_rot, barrel_rot, cone_wr, barrel_wr;

  assign land      = '{x: item_q.land_x, y: item_q.land_y};
  assign ego       = '{x: item_q.ego_x, y: item_q.ego_y};
  assign is_barrel = (item_q.table_select == ldm_pkg::TBL_BARREL);
  assign is_query  = (item_q.op == ldm_pkg::OP_QUERY);
  assign sel_cnt   = is_barrel ? barrel_cnt_q : cone_cnt_q;
  assign head      = is_barrel ? barrel_head : cone_head;

  assign new_entry = !is_query && in_range_q && !dup_q;
  assign room      = sel_cnt < ldm_pkg::CNT_W'(ldm_pkg::TABLE_DEPTH);
  assign do_write  = (state_q == ST_FINISH) && new_entry && room;
  assign cnt_after = sel_cnt + ldm_pkg::CNT_W'(do_write);
  assign uturn_set = is_query && !is_barrel && found_q
                     && (sel_cnt >= ldm_pkg::CNT_W'(2))
                     && (best_q <= ldm_pkg::DIST_W'(uturn_rad_q));

  assign cone_rot   = (state_q == ST_SCAN) && !is_barrel;
  assign barrel_rot = (state_q == ST_SCAN) && is_barrel;
  assign cone_wr    = do_write && !is_barrel;
  assign barrel_wr  = do_write && is_barrel;

  always_comb begin
    feed_a   = head;
    feed_b   = is_query ? ego : land;
    feed_tag = '0;
    unique case (state_q)
      ST_RANGE: begin
        feed_a            = land;
        feed_b            = ego;
        feed_tag.valid    = 1'b1;
        feed_tag.is_range = 1'b1;
      end
      ST_SCAN: begin
        feed_tag.valid = ldm_pkg::CNT_W'(k_q) < sel_cnt;
        feed_tag.pos   = head;
      end
      default: begin
        feed_tag = '0;
      end
    endcase
  end

  ldm_chain u_cone (
    .clk_i   (clk_i),
    .rot_i   (cone_rot),
    .wr_i    (cone_wr),
    .widx_i  (sel_cnt[ldm_pkg::IDX_W-1:0]),
    .wdata_i (land),
    .head_o  (cone_head)
  );

  ldm_chain u_barrel (
    .clk_i   (clk_i),
    .rot_i   (barrel_rot),
    .wr_i    (barrel_wr),
    .widx_i  (sel_cnt[ldm_pkg::IDX_W-1:0]),
    .wdata_i (land),
    .head_o  (barrel_head)
  );

  ldm_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (feed_a),
    .b_i    (feed_b),
    .tag_i  (feed_tag),
    .dist_o (dist_val),
    .tag_o  (dist_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dedup_q     <= ldm_pkg::CFG_W'(36864);
      range_q     <= ldm_pkg::CFG_W'(9437184);
      uturn_rad_q <= ldm_pkg::CFG_W'(589824);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ldm_pkg::CFG_DEDUP_RADIUS: dedup_q     <= cfg_data_i;
        ldm_pkg::CFG_RANGE_LIMIT:  range_q     <= cfg_data_i;
        ldm_pkg::CFG_UTURN_RADIUS: uturn_rad_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_q       <= '0;
      k_q          <= '0;
      drain_q      <= '0;
      cone_cnt_q   <= '0;
      barrel_cnt_q <= '0;
      uturn_q      <= 1'b0;
      in_range_q   <= 1'b0;
      dup_q        <= 1'b0;
      found_q      <= 1'b0;
      best_q       <= '0;
      best_pos_q   <= '0;
      done_q       <= 1'b0;
      result_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (dist_tag.valid) begin
        if (dist_tag.is_range) begin
          in_range_q <= dist_val < ldm_pkg::DIST_W'(range_q);
        end else if (!is_query) begin
          if (dist_val < ldm_pkg::DIST_W'(dedup_q)) begin
            dup_q <= 1'b1;
          end
        end else if (!found_q || dist_val < best_q) begin
          found_q    <= 1'b1;
          best_q     <= dist_val;
          best_pos_q <= dist_tag.pos;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            item_q     <= item_i;
            in_range_q <= 1'b0;
            dup_q      <= 1'b0;
            found_q    <= 1'b0;
            best_q     <= '0;
            best_pos_q <= '0;
            k_q        <= '0;
            state_q    <= ST_RANGE;
          end
        end
        ST_RANGE: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          k_q <= k_q + 1'b1;
          if (k_q == ldm_pkg::IDX_W'(ldm_pkg::TABLE_DEPTH - 1)) begin
            drain_q <= '0;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == ldm_pkg::DRAIN_W'(ldm_pkg::DIST_LAT - 1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (is_barrel) begin
            barrel_cnt_q <= cnt_after;
          end else begin
            cone_cnt_q <= cnt_after;
          end
          if (uturn_set) begin
            uturn_q <= 1'b1;
          end
          result_q.accepted     <= do_write;
          result_q.table_full   <= new_entry && !room;
          result_q.found        <= is_query && found_q;
          result_q.near_x       <= (is_query && found_q) ? best_pos_q.x : '0;
          result_q.near_y       <= (is_query && found_q) ? best_pos_q.y : '0;
          result_q.near_dist_sq <= (is_query && found_q) ? best_q[ldm_pkg::NEAR_D_W-1:0] : '0;
          result_q.entry_count  <= ldm_pkg::COUNT_OUT_W'(cnt_after);
          result_q.uturn        <= uturn_q || uturn_set;
          done_q                <= 1'b1;
          state_q               <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FINISH))
    else $error("result strobe without finish");

  a_uturn_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(uturn_q) |-> uturn_q)
    else $error("u-turn latch cleared");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cone_cnt_q <= ldm_pkg::CNT_W'(ldm_pkg::TABLE_DEPTH))
    && (barrel_cnt_q <= ldm_pkg::CNT_W'(ldm_pkg::TABLE_DEPTH)))
    else $error("table count overflow");

  a_no_tag_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !dist_tag.valid)
    else $error("distance result pending while idle");

  a_offer_no_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.accepted || result_o.table_full)) |-> !result_o.found)
    else $error("offer result carries a query hit");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the landmark dedup map: directed probes, then randomized phases.
`timescale 1ns / 100ps

module testbench;
  import ldm_pkg::*;

  localparam logic [CFG_W-1:0] DEDUP_RESET   = 40'd36864;
  localparam logic [CFG_W-1:0] RANGE_RESET   = 40'd9437184;
  localparam logic [CFG_W-1:0] UTURN_RESET   = 40'd589824;
  localparam logic [CFG_W-1:0] CFG_ALL_ONES  = {CFG_W{1'b1}};
  // index past the register list; the block must drop these writes
  localparam logic [1:0]       CFG_IDX_SPARE = 2'd3;
  localparam longint           COORD_MAX     = 8388607;
  localparam longint           COORD_MIN     = -8388608;
  localparam int               SETTLE_CYCLES = TABLE_DEPTH + 40;
  localparam int               RUN_LIMIT_NS  = 10_000_000;
  localparam int               PRINT_CAP     = 40;

  typedef enum {FILL_BARREL, NEAR_EGO, FULL_SPAN} mix_e;

  typedef struct {
    in_t  item;
    bit   pinned;
    out_t want;
  } probe_t;

  typedef struct {
    logic [CFG_W-1:0] dedup;
    logic [CFG_W-1:0] rng;
    logic [CFG_W-1:0] ut;
    mix_e             mix;
    int               n;
    bit               spare;
  } stage_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  in_t              item_i;
  logic             done_o;
  out_t             result_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  // map state as the block should hold it
  entry_t           land_tbl [2][TABLE_DEPTH];
  int unsigned      land_cnt [2] = '{0, 0};
  logic             uturn_hold = 1'b0;
  logic [CFG_W-1:0] dedup_rad = DEDUP_RESET;
  logic [CFG_W-1:0] range_lim = RANGE_RESET;
  logic [CFG_W-1:0] uturn_rad = UTURN_RESET;

  out_t             reply_q [$];
  probe_t           probes [$];
  stage_t           stages [$];

  logic signed [COORD_W-1:0] walk_x = '0;
  logic signed [COORD_W-1:0] walk_y = '0;

  int mismatch_cnt = 0;
  int result_idx   = 0;
  int sent_cnt     = 0;
  int quiet_left   = 0;
  int stored_cnt   = 0;
  int dup_cnt      = 0;
  int far_cnt      = 0;
  int full_cnt     = 0;
  int query_cnt    = 0;
  int miss_cnt     = 0;

  landmark_dedup_map_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout: %0d results still owed after %0d transactions", reply_q.size(), sent_cnt);
    $display("testbench: FAIL");
    $finish;
  end

  function automatic longint sq_dist(logic signed [COORD_W-1:0] px,
                                     logic signed [COORD_W-1:0] py,
                                     logic signed [COORD_W-1:0] qx,
                                     logic signed [COORD_W-1:0] qy);
    longint dx;
    longint dy;
    dx = longint'(px) - longint'(qx);
    dy = longint'(py) - longint'(qy);
    return dx * dx + dy * dy;
  endfunction

  function automatic out_t landmark_map_step(in_t it);
    out_t        r;
    int unsigned n;
    longint      best;
    longint      d;
    logic        sel;
    bit          dup;
    r   = '0;
    sel = it.table_select;
    n   = land_cnt[sel];
    if (it.op == OP_OFFER) begin
      if (sq_dist(it.land_x, it.land_y, it.ego_x, it.ego_y) < range_lim) begin
        dup = 1'b0;
        for (int i = 0; i < n; i++)
          if (sq_dist(land_tbl[sel][i].x, land_tbl[sel][i].y, it.land_x, it.land_y) < dedup_rad)
            dup = 1'b1;
        if (dup) begin
          dup_cnt++;
        end else if (n >= TABLE_DEPTH) begin
          r.table_full = 1'b1;
          full_cnt++;
        end else begin
          land_tbl[sel][n].x = it.land_x;
          land_tbl[sel][n].y = it.land_y;
          n++;
          land_cnt[sel] = n;
          r.accepted = 1'b1;
          stored_cnt++;
        end
      end else begin
        far_cnt++;
      end
    end else begin
      query_cnt++;
      if (n == 0) begin
        miss_cnt++;
      end else begin
        r.found  = 1'b1;
        r.near_x = land_tbl[sel][0].x;
        r.near_y = land_tbl[sel][0].y;
        best     = sq_dist(it.ego_x, it.ego_y, r.near_x, r.near_y);
        for (int i = 1; i < n; i++) begin
          d = sq_dist(it.ego_x, it.ego_y, land_tbl[sel][i].x, land_tbl[sel][i].y);
          if (d < best) begin
            best     = d;
            r.near_x = land_tbl[sel][i].x;
            r.near_y = land_tbl[sel][i].y;
          end
        end
        r.near_dist_sq = best[NEAR_D_W-1:0];
        if (sel == TBL_CONE && n >= 2 && best <= uturn_rad) uturn_hold = 1'b1;
      end
    end
    r.entry_count = COUNT_OUT_W'(n);
    r.uturn       = uturn_hold;
    return r;
  endfunction

  function automatic in_t offer(logic sel, int lx, int ly, int ex, int ey);
    in_t it;
    it              = '0;
    it.op           = OP_OFFER;
    it.table_select = sel;
    it.land_x       = COORD_W'(lx);
    it.land_y       = COORD_W'(ly);
    it.ego_x        = COORD_W'(ex);
    it.ego_y        = COORD_W'(ey);
    return it;
  endfunction

  function automatic in_t query(logic sel, int ex, int ey);
    in_t it;
    it              = '0;
    it.op           = OP_QUERY;
    it.table_select = sel;
    it.ego_x        = COORD_W'(ex);
    it.ego_y        = COORD_W'(ey);
    return it;
  endfunction

  function automatic out_t res(bit acc, bit full, bit fnd, int nx, int ny, longint nd,
                               int cnt, bit ut);
    out_t r;
    r.accepted     = acc;
    r.table_full   = full;
    r.found        = fnd;
    r.near_x       = COORD_W'(nx);
    r.near_y       = COORD_W'(ny);
    r.near_dist_sq = NEAR_D_W'(nd);
    r.entry_count  = COUNT_OUT_W'(cnt);
    r.uturn        = ut;
    return r;
  endfunction

  function automatic void add_probe(in_t it, bit pinned, out_t want);
    probe_t p;
    p.item   = it;
    p.pinned = pinned;
    p.want   = want;
    probes.insert(probes.size(), p);
  endfunction

  function automatic void add_stage(logic [CFG_W-1:0] dedup, logic [CFG_W-1:0] rng,
                                    logic [CFG_W-1:0] ut, mix_e mix, int n, bit spare);
    stage_t s;
    s.dedup = dedup;
    s.rng   = rng;
    s.ut    = ut;
    s.mix   = mix;
    s.n     = n;
    s.spare = spare;
    stages.insert(stages.size(), s);
  endfunction

  function automatic logic signed [COORD_W-1:0] jitter(logic signed [COORD_W-1:0] c, int span);
    longint v;
    v = longint'(c) + longint'($urandom_range(2 * span)) - span;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic in_t draw_item(mix_e mix);
    in_t         it;
    entry_t      e;
    int unsigned n;
    it = '0;
    case (mix)
      FILL_BARREL: begin
        it.op           = ($urandom_range(99) < 8) ? OP_QUERY : OP_OFFER;
        it.table_select = (it.op == OP_OFFER || $urandom_range(1) == 1) ? TBL_BARREL : TBL_CONE;
        it.ego_x        = jitter('0, 4000000);
        it.ego_y        = jitter('0, 4000000);
        it.land_x       = jitter(it.ego_x, 700000);
        it.land_y       = jitter(it.ego_y, 700000);
      end
      NEAR_EGO: begin
        it.op           = ($urandom_range(99) < 35) ? OP_QUERY : OP_OFFER;
        it.table_select = ($urandom_range(99) < 70) ? TBL_CONE : TBL_BARREL;
        walk_x          = jitter(walk_x, 1500);
        walk_y          = jitter(walk_y, 1500);
        it.ego_x        = walk_x;
        it.ego_y        = walk_y;
        n               = land_cnt[it.table_select];
        // land near a stored entry to probe the merge radius edge
        if (n > 0 && $urandom_range(3) == 0) begin
          e         = land_tbl[it.table_select][$urandom_range(n - 1)];
          it.land_x = jitter(e.x, 260);
          it.land_y = jitter(e.y, 260);
        end else begin
          it.land_x = jitter(walk_x, 4000);
          it.land_y = jitter(walk_y, 4000);
        end
      end
      default: begin
        it.op           = 1'($urandom);
        it.table_select = 1'($urandom);
        it.land_x       = COORD_W'($urandom);
        it.land_y       = COORD_W'($urandom);
        it.ego_x        = COORD_W'($urandom);
        it.ego_y        = COORD_W'($urandom);
      end
    endcase
    return it;
  endfunction

  function automatic int pick_gap();
    int p;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(29) == 0) quiet_left = 20;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 80) return $urandom_range(3, 1);
    if (p < 95) return $urandom_range(40, 4);
    return $urandom_range(300, 41);
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP)
      $display("mismatch at %0t, result %0d, %s: got %0h want %0h",
               $time, result_idx, field, got, want);
  endtask

  task automatic send_item(input in_t it, input bit pinned, input out_t want);
    int   gap;
    out_t got;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    got = landmark_map_step(it);
    reply_q.insert(reply_q.size(), pinned ? want : got);
    sent_cnt++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0 || busy);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] dedup, input logic [CFG_W-1:0] rng,
                              input logic [CFG_W-1:0] ut, input bit spare);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DEDUP_RADIUS;
    cfg_data_i <= dedup;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RANGE_LIMIT;
    cfg_data_i <= rng;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_UTURN_RADIUS;
    cfg_data_i <= ut;
    @(posedge clk_i);
    if (spare) begin
      cfg_idx_i  <= CFG_IDX_SPARE;
      cfg_data_i <= CFG_W'({$urandom, $urandom});
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    dedup_rad = dedup;
    range_lim = rng;
    uturn_rad = ut;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && done_o) begin
      result_idx++;
      if (reply_q.size() == 0) begin
        report_mismatch("result with no transaction owed", 0, 0);
      end else begin
        want = reply_q.pop_front();
        if (result_o.accepted !== want.accepted)
          report_mismatch("accepted", result_o.accepted, want.accepted);
        if (result_o.table_full !== want.table_full)
          report_mismatch("table_full", result_o.table_full, want.table_full);
        if (result_o.found !== want.found)
          report_mismatch("found", result_o.found, want.found);
        if (result_o.near_x !== want.near_x)
          report_mismatch("near_x", result_o.near_x, want.near_x);
        if (result_o.near_y !== want.near_y)
          report_mismatch("near_y", result_o.near_y, want.near_y);
        if (result_o.near_dist_sq !== want.near_dist_sq)
          report_mismatch("near_dist_sq", result_o.near_dist_sq, want.near_dist_sq);
        if (result_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", result_o.entry_count, want.entry_count);
        if (result_o.uturn !== want.uturn)
          report_mismatch("uturn", result_o.uturn, want.uturn);
      end
    end
  end

  initial begin
    start      <= 1'b0;
    item_i     <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_DEDUP_RADIUS;
    cfg_data_i <= '0;
    rst_ni     <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: merge 192, range 3072, u-turn 768 (all squared)
    add_probe(query(TBL_CONE, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(query(TBL_BARREL, -8388608, 8388607), 1'b1, res(0, 0, 0, 0, 0, 0, 0, 0));
    // exactly at the range limit: rejected
    add_probe(offer(TBL_CONE, 3072, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(offer(TBL_CONE, 100, 0, 0, 0), 1'b0, '0);
    add_probe(offer(TBL_CONE, 291, 0, 0, 0), 1'b0, '0);
    // single cone within u-turn radius must not latch
    add_probe(query(TBL_CONE, 100, 0), 1'b0, '0);
    // exactly on the merge radius: stored
    add_probe(offer(TBL_CONE, 292, 0, 0, 0), 1'b0, '0);
    add_probe(offer(TBL_BARREL, -8388608, -8388608, -8388608, -8388608), 1'b0, '0);
    add_probe(query(TBL_BARREL, 8388607, 8388607), 1'b1,
              res(0, 0, 1, -8388608, -8388608, 562949886312450, 1, 0));
    add_probe(offer(TBL_BARREL, 8388607, 8388607, -8388608, -8388608), 1'b1,
              res(0, 0, 0, 0, 0, 0, 1, 0));
    add_probe(offer(TBL_BARREL, -8388400, -8388608, -8388608, -8388608), 1'b0, '0);
    // barrel query never latches
    add_probe(query(TBL_BARREL, -8388500, -8388608), 1'b0, '0);
    add_probe(query(TBL_CONE, 0, 2000), 1'b0, '0);
    // equidistant cones: first one wins, latch sets
    add_probe(query(TBL_CONE, 196, 0), 1'b0, '0);
    add_probe(offer(TBL_CONE, -2000, -1500, -100, -100), 1'b0, '0);
    add_probe(offer(TBL_CONE, -2000, -1500, 0, 0), 1'b0, '0);
    add_probe(query(TBL_CONE, -1900, -1400), 1'b0, '0);
    add_probe(offer(TBL_CONE, 3071, 0, 0, 0), 1'b0, '0);
    add_probe(offer(TBL_BARREL, 0, 0, 0, 0), 1'b0, '0);
    add_probe(query(TBL_BARREL, 0, 0), 1'b0, '0);
    add_probe(query(TBL_CONE, -8388608, -8388608), 1'b0, '0);
    add_probe(offer(TBL_CONE, 8388607, -8388608, 8388607, -8388600), 1'b0, '0);
    add_probe(query(TBL_CONE, 8388607, 8388607), 1'b0, '0);
    foreach (probes[k]) send_item(probes[k].item, probes[k].pinned, probes[k].want);

    add_stage('0, CFG_ALL_ONES, '0, FILL_BARREL, 300, 1'b1);
    add_stage(DEDUP_RESET, RANGE_RESET, UTURN_RESET, NEAR_EGO, 300, 1'b0);
    add_stage(CFG_ALL_ONES, '0, '0, FULL_SPAN, 80, 1'b1);
    add_stage(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, NEAR_EGO, 80, 1'b0);
    repeat (2)
      add_stage(CFG_W'($urandom_range(200000)), CFG_W'($urandom_range(1 << 26)),
                CFG_W'({$urandom, $urandom}), NEAR_EGO, 75, 1'b0);
    foreach (stages[s]) begin
      drain();
      program_regs(stages[s].dedup, stages[s].rng, stages[s].ut, stages[s].spare);
      for (int k = 0; k < stages[s].n; k++) begin
        if ($urandom_range(59) == 0) drain();
        send_item(draw_item(stages[s].mix), 1'b0, '0);
      end
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run: %0d transactions over %0d threshold settings; offers %0d stored, %0d merged,",
             sent_cnt, stages.size() + 1, stored_cnt, dup_cnt);
    $display("run: %0d out of range, %0d refused on full table; %0d queries, %0d on empty tables",
             far_cnt, full_cnt, query_cnt, miss_cnt);
    if (mismatch_cnt == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ldm_pkg.sv
hdl/ldm_cell.sv
hdl/ldm_chain.sv
hdl/ldm_dist.sv
hdl/landmark_dedup_map_top.sv
tb/sv/testbench.sv
